// File: hw/rtl/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Types, constants and codes shared by the voice allocator modules.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int NUM_VOICES  = 8;
  localparam int ACTIVE_BITS = 8;
  localparam int VIDX_W      = $clog2(NUM_VOICES);
  localparam int NOTE_W      = 7;
  localparam int VEL_W       = 7;
  localparam int IDX_FIELD_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input operation codes
  localparam logic [1:0] FUNC_NOTE_ON  = 2'd0;
  localparam logic [1:0] FUNC_NOTE_OFF = 2'd1;
  localparam logic [1:0] FUNC_ALL_OFF  = 2'd2;

  // Classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [NOTE_W-1:0]        note;
    logic [VEL_W-1:0]         vel;
    logic [ACTIVE_BITS-1:0]   active;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

// File: hw/rtl/mva_channels.sv
// ----------------------------------------------------------------------------
// mva channels
// Valid/ready channels for the event input and the allocation result.
// ----------------------------------------------------------------------------
interface mva_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] note_number;
  logic [6:0] note_velocity;
  logic [7:0] voices_active;

  modport source (output valid, func, note_number, note_velocity, voices_active,
                  input ready);
  modport sink   (input valid, func, note_number, note_velocity, voices_active,
                  output ready);
endinterface

interface mva_out_if;
  logic       valid;
  logic       ready;
  logic       start_voice;
  logic [2:0] voice_index;
  logic [6:0] start_note;
  logic [6:0] start_velocity;
  logic [7:0] release_mask;
  logic       reset_all;

  modport source (output valid, start_voice, voice_index, start_note, start_velocity,
                  release_mask, reset_all, input ready);
  modport sink   (input valid, start_voice, voice_index, start_note, start_velocity,
                  release_mask, reset_all, output ready);
endinterface

// File: hw/rtl/mva_front.sv
// ----------------------------------------------------------------------------
// mva_front
// Accepts events and classifies them into start, release, clear or no-op.
// ----------------------------------------------------------------------------
module mva_front (
  mva_in_if.sink         in_ch,
  input  logic           full,
  output mva_pkg::push_t push
);

  mva_pkg::op_t op;

  always_comb begin
    unique case (in_ch.func)
      mva_pkg::FUNC_NOTE_ON: begin
        // zero velocity counts as a note-off
        op = (in_ch.note_velocity == '0) ? mva_pkg::OP_RELEASE : mva_pkg::OP_START;
      end
      mva_pkg::FUNC_NOTE_OFF: op = mva_pkg::OP_RELEASE;
      mva_pkg::FUNC_ALL_OFF:  op = mva_pkg::OP_CLEAR;
      default:                op = mva_pkg::OP_NONE;
    endcase
  end

  assign in_ch.ready        = !full;
  assign push.valid         = in_ch.valid && !full;
  assign push.entry.op      = op;
  assign push.entry.note    = in_ch.note_number;
  assign push.entry.vel     = in_ch.note_velocity;
  assign push.entry.active  = in_ch.voices_active;

endmodule

// File: hw/rtl/mva_queue.sv
// ----------------------------------------------------------------------------
// mva_queue
// Short queue of classified events between the front and back ends.
// ----------------------------------------------------------------------------
module mva_queue (
  input  logic           clk,
  input  logic           rst,
  input  mva_pkg::push_t push,
  input  logic           pop,
  output logic           full,
  output mva_pkg::head_t head
);

  mva_pkg::entry_t               mem [mva_pkg::QUEUE_DEPTH];
  logic [mva_pkg::QPTR_W-1:0]    wr_ptr;
  logic [mva_pkg::QPTR_W-1:0]    rd_ptr;
  logic [mva_pkg::QPTR_W:0]      count;
  logic                          do_push;
  logic                          do_pop;

  assign full       = (count == (mva_pkg::QPTR_W+1)'(mva_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/mva_back.sv
// ----------------------------------------------------------------------------
// mva_back
// Carries out queued events against the voice table and holds the result word.
// ----------------------------------------------------------------------------
module mva_back (
  input  logic           clk,
  input  logic           rst,
  input  mva_pkg::head_t head,
  output logic           pop,
  mva_out_if.source      out_ch
);

  logic [mva_pkg::NOTE_W-1:0]  voice_note [mva_pkg::NUM_VOICES];
  logic [mva_pkg::VIDX_W-1:0]  last_voice;
  logic [mva_pkg::VIDX_W-1:0]  last_voice_next;

  logic [mva_pkg::NUM_VOICES-1:0] act;
  logic [mva_pkg::NUM_VOICES-1:0] match;
  logic                           match_any;
  logic [mva_pkg::VIDX_W-1:0]     match_idx;
  logic                           free_any;
  logic [mva_pkg::VIDX_W-1:0]     free_idx;
  logic [mva_pkg::VIDX_W-1:0]     steal_idx;
  logic [mva_pkg::VIDX_W-1:0]     target;
  logic [mva_pkg::VIDX_W:0]       cand;
  logic [mva_pkg::VIDX_W:0]       cand_wrap [mva_pkg::NUM_VOICES];

  logic       load;
  logic       is_start;
  logic [7:0] rel_mask;

  assign load     = head.valid && (!out_ch.valid || out_ch.ready);
  assign pop      = load;
  assign is_start = (head.entry.op == mva_pkg::OP_START);

  always_comb begin
    for (int v = 0; v < mva_pkg::NUM_VOICES; v++) begin
      // voices past the activity mask never sound
      if (v < mva_pkg::ACTIVE_BITS) begin
        act[v] = head.entry.active[v];
      end else begin
        act[v] = 1'b0;
      end
      match[v] = act[v] && (voice_note[v] == head.entry.note);
    end
  end

  // lowest active voice already holding the note
  always_comb begin
    match_any = |match;
    match_idx = '0;
    for (int v = mva_pkg::NUM_VOICES - 1; v >= 0; v--) begin
      if (match[v]) begin
        match_idx = mva_pkg::VIDX_W'(v);
      end
    end
  end

  // round-robin candidates after last_voice, first inactive wins
  always_comb begin
    for (int i = 0; i < mva_pkg::NUM_VOICES; i++) begin
      cand = (mva_pkg::VIDX_W+1)'(last_voice) + (mva_pkg::VIDX_W+1)'(i + 1);
      if (cand >= (mva_pkg::VIDX_W+1)'(mva_pkg::NUM_VOICES)) begin
        cand = cand - (mva_pkg::VIDX_W+1)'(mva_pkg::NUM_VOICES);
      end
      cand_wrap[i] = cand;
    end
    free_any = 1'b0;
    free_idx = '0;
    for (int i = mva_pkg::NUM_VOICES - 1; i >= 0; i--) begin
      if (!act[cand_wrap[i][mva_pkg::VIDX_W-1:0]]) begin
        free_any = 1'b1;
        free_idx = cand_wrap[i][mva_pkg::VIDX_W-1:0];
      end
    end
    steal_idx = cand_wrap[0][mva_pkg::VIDX_W-1:0];
  end

  always_comb begin
    priority if (match_any) begin
      target          = match_idx;
      last_voice_next = last_voice;
    end else if (free_any) begin
      target          = free_idx;
      last_voice_next = free_idx;
    end else begin
      target          = steal_idx;
      last_voice_next = steal_idx;
    end
  end

  always_comb begin
    rel_mask = '0;
    for (int v = 0; v < mva_pkg::NUM_VOICES && v < 8; v++) begin
      rel_mask[v] = match[v];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_voice <= '0;
      for (int v = 0; v < mva_pkg::NUM_VOICES; v++) begin
        voice_note[v] <= '0;
      end
    end else if (load && is_start) begin
      last_voice         <= last_voice_next;
      voice_note[target] <= head.entry.note;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // result word: hold until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.start_voice    <= is_start;
      out_ch.voice_index    <= is_start ? mva_pkg::IDX_FIELD_W'(target) : '0;
      out_ch.start_note     <= is_start ? head.entry.note : '0;
      out_ch.start_velocity <= is_start ? head.entry.vel : '0;
      out_ch.release_mask   <= (head.entry.op == mva_pkg::OP_RELEASE) ? rel_mask : '0;
      out_ch.reset_all      <= (head.entry.op == mva_pkg::OP_CLEAR);
    end
  end

endmodule

// File: hw/rtl/midi_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// midi_voice_allocator_unit
// Assigns note events to eight synthesizer voices with round-robin stealing.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one event word per handshake: func, note_number,
//   note_velocity and the voice-activity mask from the voice engines.
//   out_ch returns one result word per event, in event order: the started
//   voice with its note and velocity, a release mask, or reset_all.
//   The front end classifies each accepted event into a two-entry queue at
//   the edge it is taken. The back end reads the queue head, searches the
//   eight-entry voice table combinationally and loads the result register,
//   so each event passes the queue and then the result register before
//   out_ch.valid rises for it.
//   Throughput is one event per cycle while out_ch takes results.
//   When out_ch stalls, the result register holds its word, the queue fills,
//   and in_ch.ready drops once both queue entries are occupied.
//   Synchronous reset empties the queue and the result register, clears
//   every stored voice note to zero and sets the last voice to zero.
// ----------------------------------------------------------------------------
module midi_voice_allocator_unit (
  input  logic      clk,
  input  logic      rst,
  mva_in_if.sink    in_ch,
  mva_out_if.source out_ch
);

  mva_pkg::push_t push;
  mva_pkg::head_t head;
  logic           full;
  logic           pop;

  mva_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .push  (push)
  );

  mva_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  mva_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
